// ===== hw/rtl/particle_stream_wall_bounce_unit_assert.svh =====
`ifndef PARTICLE_STREAM_WALL_BOUNCE_UNIT_ASSERT_SVH
`define PARTICLE_STREAM_WALL_BOUNCE_UNIT_ASSERT_SVH

// ante must be followed by cons in the same cycle
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// bad must never be seen
`define PSW_ASSERT_NEVER(lbl, clk, rst_n, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(bad)) \
        else $error(msg);

`endif

// ===== hw/rtl/psw_pkg.sv =====
package psw_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP,
        CFG_BOX_X,
        CFG_BOX_Y,
        CFG_BOX_Z
    } t_cfg_idx;

    typedef enum logic [2:0] {
        WALL_Z_LO,
        WALL_Z_HI,
        WALL_Y_LO,
        WALL_Y_HI,
        CRN_YL_ZL,
        CRN_YL_ZH,
        CRN_YH_ZL,
        CRN_YH_ZH
    } t_wall;

    localparam int unsigned N_WALLS    = 8;
    localparam int unsigned DIV_STEPS  = 32;
    // setup, divide steps, time select, multiply, apply
    localparam int unsigned BNC_LAT    = DIV_STEPS + 4;
    localparam int unsigned WRAP_STEPS = 32;
    // stream (2), walls, wrap setup + steps, output
    localparam int unsigned LATENCY    = 2 + N_WALLS * BNC_LAT + WRAP_STEPS + 2;

    localparam t_wall WALL_ORDER [0:N_WALLS-1] = '{
        WALL_Z_LO, WALL_Z_HI, WALL_Y_LO, WALL_Y_HI,
        CRN_YL_ZL, CRN_YL_ZH, CRN_YH_ZL, CRN_YH_ZH
    };

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [49:0] W_MAX   = 50'sd2147483647;
    localparam logic signed [49:0] W_MIN   = -50'sd2147483648;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               in_list;
        logic               last_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               last_out;
    } t_out;

    // particle state moving down the pipe
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               free;
        logic               last;
    } t_part;

    // restoring divider state, one quotient bit per stage
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] quo;
        logic [31:0] low;
        logic [31:0] den;
        logic        ovf;
        logic        neg;
        logic        zero;
    } t_div;

    // floored remainder state, one dividend bit per stage
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] mag;
        logic        neg;
    } t_wrap;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > W_MAX) begin
            return S32_MAX;
        end else if (x < W_MIN) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == S32_MIN) begin
            return S32_MAX;
        end
        return -v;
    endfunction

endpackage

// ===== hw/rtl/psw_bounce.sv =====
module psw_bounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psw_pkg::t_wall    i_kind,
    input  logic [30:0]       i_box_y,
    input  logic [30:0]       i_box_z,
    input  logic              i_valid,
    input  psw_pkg::t_part    i_part,
    output logic              o_valid,
    output psw_pkg::t_part    o_part
);

    localparam int unsigned NS = psw_pkg::DIV_STEPS;

    function automatic psw_pkg::t_div div_init(input logic signed [32:0] over,
                                               input logic signed [31:0] vel);
        psw_pkg::t_div d;
        logic [32:0]   mag;
        logic [48:0]   num;
        mag    = over[32] ? 33'(-over) : 33'(over);
        num    = {mag[32:0], 16'b0};
        d.den  = vel[31] ? 32'(-vel) : 32'(vel);
        d.rem  = {16'b0, num[48:32]};
        d.low  = num[31:0];
        d.quo  = '0;
        d.ovf  = d.rem >= {1'b0, d.den};
        d.neg  = over[32] ^ vel[31];
        d.zero = (vel == 32'sd0);
        return d;
    endfunction

    function automatic psw_pkg::t_div div_step(input psw_pkg::t_div d);
        psw_pkg::t_div n;
        logic [32:0]   r2;
        n  = d;
        r2 = {d.rem[31:0], d.low[31]};
        if (r2 >= {1'b0, d.den}) begin
            n.rem = r2 - {1'b0, d.den};
            n.quo = {d.quo[30:0], 1'b1};
        end else begin
            n.rem = r2;
            n.quo = {d.quo[30:0], 1'b0};
        end
        n.low = {d.low[30:0], 1'b0};
        return n;
    endfunction

    function automatic logic signed [31:0] div_time(input psw_pkg::t_div d);
        if (d.zero) begin
            return 32'sd0;
        end else if (d.ovf) begin
            return d.neg ? psw_pkg::S32_MIN : psw_pkg::S32_MAX;
        end else if (d.neg) begin
            if (d.quo > 32'h80000000) begin
                return psw_pkg::S32_MIN;
            end
            return $signed(32'(-d.quo));
        end else if (d.quo[31]) begin
            return psw_pkg::S32_MAX;
        end
        return $signed(d.quo);
    endfunction

    logic                w_y_hi, w_z_hi, w_use_y, w_use_z, w_hit;
    logic signed [32:0]  w_py, w_pz, w_by, w_bz, w_oy, w_oz;

    always_comb begin
        w_py = 33'(i_part.py);
        w_pz = 33'(i_part.pz);
        w_by = $signed({2'b00, i_box_y});
        w_bz = $signed({2'b00, i_box_z});
        w_y_hi  = 1'b0;
        w_z_hi  = 1'b0;
        w_use_y = 1'b1;
        w_use_z = 1'b1;
        w_hit   = 1'b0;
        case (i_kind)
            psw_pkg::WALL_Z_LO: begin
                w_use_y = 1'b0;
                w_hit   = w_pz < 33'sd0 && w_py < w_by && w_py > 33'sd0;
            end
            psw_pkg::WALL_Z_HI: begin
                w_use_y = 1'b0;
                w_z_hi  = 1'b1;
                w_hit   = w_pz > w_bz && w_py < w_by && w_py > 33'sd0;
            end
            psw_pkg::WALL_Y_LO: begin
                w_use_z = 1'b0;
                w_hit   = w_py < 33'sd0 && w_pz < w_bz && w_pz > 33'sd0;
            end
            psw_pkg::WALL_Y_HI: begin
                w_use_z = 1'b0;
                w_y_hi  = 1'b1;
                w_hit   = w_py > w_by && w_pz < w_bz && w_pz > 33'sd0;
            end
            psw_pkg::CRN_YL_ZL: begin
                w_hit = w_py < 33'sd0 && w_pz < 33'sd0;
            end
            psw_pkg::CRN_YL_ZH: begin
                w_z_hi = 1'b1;
                w_hit  = w_py < 33'sd0 && w_pz > w_bz;
            end
            psw_pkg::CRN_YH_ZL: begin
                w_y_hi = 1'b1;
                w_hit  = w_py > w_by && w_pz < 33'sd0;
            end
            psw_pkg::CRN_YH_ZH: begin
                w_y_hi = 1'b1;
                w_z_hi = 1'b1;
                w_hit  = w_py > w_by && w_pz > w_bz;
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
        w_oy = w_y_hi ? w_py - w_by : w_py;
        w_oz = w_z_hi ? w_pz - w_bz : w_pz;
    end

    // divider pipe: index 0 is the setup stage
    psw_pkg::t_div  r_dy  [0:NS];
    psw_pkg::t_div  r_dz  [0:NS];
    psw_pkg::t_part r_pp  [0:NS];
    logic           r_vv  [0:NS];
    logic           r_hit [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv[0] <= 1'b0;
        end else begin
            r_vv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dy[0]  <= div_init(w_oy, i_part.vy);
        r_dz[0]  <= div_init(w_oz, i_part.vz);
        r_pp[0]  <= i_part;
        r_hit[0] <= w_hit & i_part.free;
    end

    for (genvar j = 0; j < NS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[j+1] <= 1'b0;
            end else begin
                r_vv[j+1] <= r_vv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dy[j+1]  <= div_step(r_dy[j]);
            r_dz[j+1]  <= div_step(r_dz[j]);
            r_pp[j+1]  <= r_pp[j];
            r_hit[j+1] <= r_hit[j];
        end
    end

    // crossing time; a corner takes the later of its two times
    logic signed [31:0] w_ty, w_tz, n_t;
    always_comb begin
        w_ty = div_time(r_dy[NS]);
        w_tz = div_time(r_dz[NS]);
        if (w_use_y && w_use_z) begin
            n_t = (w_ty > w_tz) ? w_ty : w_tz;
        end else if (w_use_y) begin
            n_t = w_ty;
        end else begin
            n_t = w_tz;
        end
    end

    logic               r_t_valid, r_t_hit;
    psw_pkg::t_part     r_t_part;
    logic signed [31:0] r_t;

    logic               r_m_valid, r_m_hit;
    psw_pkg::t_part     r_m_part;
    logic signed [63:0] r_m_x, r_m_y, r_m_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_m_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_t_valid <= r_vv[NS];
            r_m_valid <= r_t_valid;
            o_valid   <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_t_hit  <= r_hit[NS];
        r_t_part <= r_pp[NS];
        r_m_x    <= $signed(r_t_part.vx) * r_t;
        r_m_y    <= $signed(r_t_part.vy) * r_t;
        r_m_z    <= $signed(r_t_part.vz) * r_t;
        r_m_hit  <= r_t_hit;
        r_m_part <= r_t_part;
    end

    // position minus twice floor(v*t / 2^16), velocity reversed
    function automatic logic signed [31:0] pull_back(input logic signed [31:0] p,
                                                     input logic signed [63:0] m);
        logic signed [48:0] d2;
        d2 = $signed({m[63:16], 1'b0});
        return psw_pkg::sat32(50'(p) - 50'(d2));
    endfunction

    psw_pkg::t_part n_out;
    always_comb begin
        n_out = r_m_part;
        if (r_m_hit) begin
            n_out.px = pull_back(r_m_part.px, r_m_x);
            n_out.py = pull_back(r_m_part.py, r_m_y);
            n_out.pz = pull_back(r_m_part.pz, r_m_z);
            n_out.vx = psw_pkg::neg_sat(r_m_part.vx);
            n_out.vy = psw_pkg::neg_sat(r_m_part.vy);
            n_out.vz = psw_pkg::neg_sat(r_m_part.vz);
        end
    end

    always_ff @(posedge i_clk) begin
        o_part <= n_out;
    end

endmodule

// ===== hw/rtl/particle_stream_wall_bounce_unit.sv =====
// Particle streaming step with bounce-back walls in y/z and a periodic box.
//
// Input: one particle beat per cycle, taken on i_start while o_busy is low.
// o_busy is high only during reset and the cycle right after it.
// Output: o_done strobes for one cycle with o_result; the receiver cannot
// hold results off, so nothing here ever stalls.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write time_step, box_x, box_y, box_z;
// write only while no particle is in flight.
//
// From accept to o_done a particle passes the streaming stages, the eight
// wall tests (each a 32-step restoring divider for the crossing time, then
// time select, multiply and apply), the periodic wrap (a 32-step remainder
// unit per axis) and the output register. Throughput is one particle per
// cycle; results come out in input order.
// Reset clears all valid bits and loads the default registers; payload
// registers are not reset.
`include "particle_stream_wall_bounce_unit_assert.svh"

module particle_stream_wall_bounce_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  psw_pkg::t_in                       i_item,
    output logic                               o_done,
    output psw_pkg::t_out                      o_result,
    input  logic                               i_cfg_we,
    input  logic [psw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [psw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned NW = psw_pkg::N_WALLS;
    localparam int unsigned WS = psw_pkg::WRAP_STEPS;

    logic [23:0] r_ts;
    logic [30:0] r_box_x, r_box_y, r_box_z;
    logic        r_busy;
    logic        w_accept;

    assign o_busy   = r_busy;
    assign w_accept = i_start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts    <= 24'd6554;
            r_box_x <= 31'd655360;
            r_box_y <= 31'd655360;
            r_box_z <= 31'd655360;
            r_busy  <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (psw_pkg::t_cfg_idx'(i_cfg_idx))
                    psw_pkg::CFG_TIME_STEP: r_ts    <= i_cfg_data[23:0];
                    psw_pkg::CFG_BOX_X:     r_box_x <= i_cfg_data;
                    psw_pkg::CFG_BOX_Y:     r_box_y <= i_cfg_data;
                    psw_pkg::CFG_BOX_Z:     r_box_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // streaming: multiply, then shift/add/saturate
    psw_pkg::t_part     n_s1;
    logic               r_s1_valid, r_s2_valid;
    psw_pkg::t_part     r_s1, r_s2, n_s2;
    logic signed [56:0] r_mx, r_my, r_mz;

    always_comb begin
        n_s1.px   = i_item.pos_x;
        n_s1.py   = i_item.pos_y;
        n_s1.pz   = i_item.pos_z;
        n_s1.vx   = i_item.vel_x;
        n_s1.vy   = i_item.vel_y;
        n_s1.vz   = i_item.vel_z;
        n_s1.free = ~i_item.in_list;
        n_s1.last = i_item.last_in;
    end

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.free) begin
            n_s2.px = psw_pkg::sat32(50'(r_s1.px) + 50'($signed(r_mx[56:16])));
            n_s2.py = psw_pkg::sat32(50'(r_s1.py) + 50'($signed(r_my[56:16])));
            n_s2.pz = psw_pkg::sat32(50'(r_s1.pz) + 50'($signed(r_mz[56:16])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_mx <= $signed({1'b0, r_ts}) * $signed(i_item.vel_x);
        r_my <= $signed({1'b0, r_ts}) * $signed(i_item.vel_y);
        r_mz <= $signed({1'b0, r_ts}) * $signed(i_item.vel_z);
        r_s2 <= n_s2;
    end

    // wall tests, one unit per test, in fixed order
    logic           w_cv [0:NW];
    psw_pkg::t_part w_cp [0:NW];

    assign w_cv[0] = r_s2_valid;
    assign w_cp[0] = r_s2;

    for (genvar k = 0; k < NW; k++) begin : g_wall
        psw_bounce u_bounce (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_kind  (psw_pkg::WALL_ORDER[k]),
            .i_box_y (r_box_y),
            .i_box_z (r_box_z),
            .i_valid (w_cv[k]),
            .i_part  (w_cp[k]),
            .o_valid (w_cv[k+1]),
            .o_part  (w_cp[k+1])
        );
    end

    // periodic wrap: floored remainder per axis
    logic [30:0]        w_box [0:2];
    logic signed [31:0] w_wp  [0:2];

    assign w_box[0] = r_box_x;
    assign w_box[1] = r_box_y;
    assign w_box[2] = r_box_z;
    assign w_wp[0]  = w_cp[NW].px;
    assign w_wp[1]  = w_cp[NW].py;
    assign w_wp[2]  = w_cp[NW].pz;

    psw_pkg::t_wrap r_wr [0:WS][0:2];
    psw_pkg::t_part r_wpart [0:WS];
    logic           r_wv [0:WS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv[0] <= 1'b0;
        end else begin
            r_wv[0] <= w_cv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpart[0] <= w_cp[NW];
    end

    for (genvar a = 0; a < 3; a++) begin : g_wrap_in
        always_ff @(posedge i_clk) begin
            r_wr[0][a].rem <= '0;
            r_wr[0][a].mag <= w_wp[a][31] ? 32'(-w_wp[a]) : 32'(w_wp[a]);
            r_wr[0][a].neg <= w_wp[a][31];
        end
    end

    for (genvar j = 0; j < WS; j++) begin : g_wrap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wv[j+1] <= 1'b0;
            end else begin
                r_wv[j+1] <= r_wv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_wpart[j+1] <= r_wpart[j];
        end

        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic [31:0] w_r2;
            assign w_r2 = {r_wr[j][a].rem[30:0], r_wr[j][a].mag[31]};

            always_ff @(posedge i_clk) begin
                r_wr[j+1][a].rem <= (w_r2 >= {1'b0, w_box[a]}) ?
                                    w_r2 - {1'b0, w_box[a]} : w_r2;
                r_wr[j+1][a].mag <= {r_wr[j][a].mag[30:0], 1'b0};
                r_wr[j+1][a].neg <= r_wr[j][a].neg;
            end
        end
    end

    logic signed [31:0] n_fp [0:2];
    logic signed [31:0] w_op [0:2];

    assign w_op[0] = r_wpart[WS].px;
    assign w_op[1] = r_wpart[WS].py;
    assign w_op[2] = r_wpart[WS].pz;

    for (genvar a = 0; a < 3; a++) begin : g_fin
        always_comb begin
            // zero box leaves the coordinate as it is
            if (w_box[a] == 31'd0) begin
                n_fp[a] = w_op[a];
            end else if (r_wr[WS][a].neg && r_wr[WS][a].rem != 32'd0) begin
                n_fp[a] = $signed({1'b0, w_box[a]} - r_wr[WS][a].rem);
            end else begin
                n_fp[a] = $signed(r_wr[WS][a].rem);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_wv[WS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.new_pos_x <= n_fp[0];
        o_result.new_pos_y <= n_fp[1];
        o_result.new_pos_z <= n_fp[2];
        o_result.new_vel_x <= r_wpart[WS].vx;
        o_result.new_vel_y <= r_wpart[WS].vy;
        o_result.new_vel_z <= r_wpart[WS].vz;
        o_result.last_out  <= r_wpart[WS].last;
    end

    `PSW_ASSERT_IMP(a_done_latency, i_clk, i_rst_n, o_done,
        $past(w_accept, psw_pkg::LATENCY), "result without matching input beat")
    `PSW_ASSERT_IMP(a_list_keeps_vel, i_clk, i_rst_n,
        o_done && $past(w_accept && i_item.in_list, psw_pkg::LATENCY),
        o_result.new_vel_y == $past(i_item.vel_y, psw_pkg::LATENCY),
        "listed particle velocity changed")
    `PSW_ASSERT_NEVER(a_x_in_box, i_clk, i_rst_n,
        o_done && r_box_x != 31'd0 &&
        (o_result.new_pos_x[31] || o_result.new_pos_x[30:0] >= r_box_x),
        "x position outside box after wrap")

endmodule

// ===== tb/tb_particle_stream_wall_bounce_unit.sv =====
module tb_particle_stream_wall_bounce_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT = int'(psw_pkg::LATENCY);
    localparam longint LIMIT = 2000000;

    // Q16.16 particle update predictor
    class bounce_scoreboard;
        longint ts, bx, by, bz;
        psw_pkg::t_out pending[$];
        int fails;
        int checked;

        function new();
            ts = 6554; bx = 655360; by = 655360; bz = 655360;
            fails = 0; checked = 0;
        endfunction

        function void set_reg(psw_pkg::t_cfg_idx idx, logic [30:0] d);
            case (idx)
                psw_pkg::CFG_TIME_STEP: ts = longint'(d[23:0]);
                psw_pkg::CFG_BOX_X: bx = longint'(d);
                psw_pkg::CFG_BOX_Y: by = longint'(d);
                psw_pkg::CFG_BOX_Z: bz = longint'(d);
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint floor16(longint x);
            return x >>> 16;
        endfunction

        function longint xtime(longint over, longint v);
            if (v == 0) return 0;
            return clip((over * 65536) / v);
        endfunction

        function void reflect(ref longint p[3], ref longint v[3], input longint t);
            for (int k = 0; k < 3; k++) p[k] = clip(p[k] - 2 * floor16(v[k] * t));
            for (int k = 0; k < 3; k++) v[k] = clip(-v[k]);
        endfunction

        function longint fold(longint p, longint b);
            longint r;
            if (b <= 0) return p;
            r = p % b;
            if (r < 0) r += b;
            return r;
        endfunction

        function longint mx(longint a, longint b);
            return a > b ? a : b;
        endfunction

        function void note_beat(psw_pkg::t_in it);
            longint p[3], v[3];
            psw_pkg::t_out o;
            p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
            v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
            if (!it.in_list) begin
                for (int k = 0; k < 3; k++) p[k] = clip(p[k] + floor16(ts * v[k]));
                if (p[2] < 0 && p[1] < by && p[1] > 0) reflect(p, v, xtime(p[2], v[2]));
                if (p[2] > bz && p[1] < by && p[1] > 0)
                    reflect(p, v, xtime(p[2] - bz, v[2]));
                if (p[1] < 0 && p[2] < bz && p[2] > 0) reflect(p, v, xtime(p[1], v[1]));
                if (p[1] > by && p[2] < bz && p[2] > 0)
                    reflect(p, v, xtime(p[1] - by, v[1]));
                if (p[1] < 0 && p[2] < 0)
                    reflect(p, v, mx(xtime(p[1], v[1]), xtime(p[2], v[2])));
                if (p[1] < 0 && p[2] > bz)
                    reflect(p, v, mx(xtime(p[1], v[1]), xtime(p[2] - bz, v[2])));
                if (p[1] > by && p[2] < 0)
                    reflect(p, v, mx(xtime(p[1] - by, v[1]), xtime(p[2], v[2])));
                if (p[1] > by && p[2] > bz)
                    reflect(p, v, mx(xtime(p[1] - by, v[1]), xtime(p[2] - bz, v[2])));
            end
            o.new_pos_x = 32'(fold(p[0], bx));
            o.new_pos_y = 32'(fold(p[1], by));
            o.new_pos_z = 32'(fold(p[2], bz));
            o.new_vel_x = 32'(v[0]); o.new_vel_y = 32'(v[1]); o.new_vel_z = 32'(v[2]);
            o.last_out = it.last_in;
            pending.push_back(o);
        endfunction

        function void cmp(string nm, longint e, longint a);
            if (e != a) begin
                $error("%s expected %0d actual %0d", nm, e, a);
                fails++;
            end
        endfunction

        function void check_result(psw_pkg::t_out r);
            psw_pkg::t_out e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                fails++;
                return;
            end
            e = pending.pop_front();
            checked++;
            cmp("new_pos_x", e.new_pos_x, r.new_pos_x);
            cmp("new_pos_y", e.new_pos_y, r.new_pos_y);
            cmp("new_pos_z", e.new_pos_z, r.new_pos_z);
            cmp("new_vel_x", e.new_vel_x, r.new_vel_x);
            cmp("new_vel_y", e.new_vel_y, r.new_vel_y);
            cmp("new_vel_z", e.new_vel_z, r.new_vel_z);
            cmp("last_out", longint'(e.last_out), longint'(r.last_out));
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_we = 0;
    logic o_busy, o_done;
    psw_pkg::t_in i_item = '0;
    psw_pkg::t_out o_result;
    logic [psw_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [psw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    longint cycles = 0;
    int sent = 0;
    bounce_scoreboard sb = new();

    particle_stream_wall_bounce_unit dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) sb.check_result(o_result);
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(psw_pkg::t_cfg_idx idx, logic [30:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    // item already driven at a negedge; holds until accepted
    task automatic push_beat(psw_pkg::t_in it, bit keep);
        i_item <= it; i_start <= 1;
        do @(posedge i_clk); while (o_busy);
        sb.note_beat(it);
        sent++;
        @(negedge i_clk);
        if (!keep) begin
            i_start <= 0;
            @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] rword();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // mostly near the box; sometimes anything
    function automatic psw_pkg::t_in rbeat(longint b);
        psw_pkg::t_in it;
        it = '0;
        if ($urandom_range(0, 4) == 0) begin
            it.pos_x = rword(); it.pos_y = rword(); it.pos_z = rword();
            it.vel_x = rword(); it.vel_y = rword(); it.vel_z = rword();
        end else begin
            it.pos_x = 32'($signed($urandom_range(0, 32'(3 * b))) - b);
            it.pos_y = 32'($signed($urandom_range(0, 32'(b + 131072))) - 65536);
            it.pos_z = 32'($signed($urandom_range(0, 32'(b + 131072))) - 65536);
            it.vel_x = $signed($urandom_range(0, 2000000)) - 1000000;
            it.vel_y = $signed($urandom_range(0, 2000000)) - 1000000;
            it.vel_z = $signed($urandom_range(0, 2000000)) - 1000000;
            if ($urandom_range(0, 9) == 0) it.vel_y = 0;
            if ($urandom_range(0, 9) == 0) it.vel_z = 0;
        end
        it.in_list = ($urandom_range(0, 5) == 0);
        it.last_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic run_random(int n);
        int left;
        int burst;
        psw_pkg::t_in it;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                it = rbeat(sb.by);
                push_beat(it, burst > 1 && left > 1);
                burst--; left--;
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    psw_pkg::t_in d;
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, walls, corners, zero divisors, in_list
        d = '0; d.pos_x = 32'h7fffffff; d.pos_y = 32'h80000000; d.pos_z = 32'h7fffffff;
        d.vel_x = 32'h80000000; d.vel_y = 32'h7fffffff; d.vel_z = 32'h80000000;
        push_beat(d, 0);
        d.in_list = 1; d.last_in = 1; push_beat(d, 0);
        d = '0; d.pos_y = 327680; d.pos_z = 100; d.vel_z = -65536 * 4; push_beat(d, 1);
        d.pos_z = 655300; d.vel_z = 65536 * 4; push_beat(d, 1);
        d.pos_z = 327680; d.pos_y = 100; d.vel_y = -65536 * 4; d.vel_z = 0; push_beat(d, 1);
        d.pos_y = 655300; d.vel_y = 65536 * 4; push_beat(d, 1);
        d.pos_y = 10; d.pos_z = 10; d.vel_y = -300000; d.vel_z = -200000; push_beat(d, 1);
        d.pos_z = 655350; d.vel_z = 200000; push_beat(d, 1);
        d.pos_y = 655350; d.vel_y = 300000; d.vel_z = -200000; d.pos_z = 10; push_beat(d, 1);
        d.pos_z = 655350; d.vel_z = 200000; push_beat(d, 1);
        d = '0; d.pos_y = -5; d.pos_z = 5; push_beat(d, 1);
        d.pos_y = 5; d.pos_z = -5; push_beat(d, 1);
        d.pos_x = 655360; d.pos_y = 655360; d.pos_z = 655360; d.in_list = 1; push_beat(d, 1);
        d.pos_x = -1; d.pos_y = -655360; d.pos_z = 32'h80000000; push_beat(d, 0);
        drain();

        write_reg(psw_pkg::CFG_TIME_STEP, 31'hffffff);
        write_reg(psw_pkg::CFG_BOX_X, 31'd65536);
        write_reg(psw_pkg::CFG_BOX_Y, 31'h7fffffff);
        write_reg(psw_pkg::CFG_BOX_Z, 31'd65536);
        run_random(100);
        drain();

        write_reg(psw_pkg::CFG_TIME_STEP, 31'd0);
        write_reg(psw_pkg::CFG_BOX_X, 31'h7fffffff);
        write_reg(psw_pkg::CFG_BOX_Y, 31'd65536);
        write_reg(psw_pkg::CFG_BOX_Z, 31'h7fffffff);
        run_random(100);
        drain();

        write_reg(psw_pkg::CFG_TIME_STEP, 31'($urandom_range(1000, 200000)));
        write_reg(psw_pkg::CFG_BOX_X, 31'($urandom_range(65536, 5000000)));
        write_reg(psw_pkg::CFG_BOX_Y, 31'($urandom_range(65536, 5000000)));
        write_reg(psw_pkg::CFG_BOX_Z, 31'($urandom_range(65536, 5000000)));
        run_random(170);
        drain();

        write_reg(psw_pkg::CFG_TIME_STEP, 31'd6554);
        write_reg(psw_pkg::CFG_BOX_X, 31'd655360);
        write_reg(psw_pkg::CFG_BOX_Y, 31'd655360);
        write_reg(psw_pkg::CFG_BOX_Z, 31'd655360);
        run_random(170);
        drain();

        $display("%0d particle beats sent, %0d results checked over five register settings",
                 sent, sb.checked);
        $display("walls, corners, zero divisors, saturation and periodic wrap exercised");
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/psw_pkg.sv
hw/rtl/psw_bounce.sv
hw/rtl/particle_stream_wall_bounce_unit.sv
tb/tb_particle_stream_wall_bounce_unit.sv
